// ----- hw/rtl/lsb_stego_message_extractor_defines.svh -----
// Assertion macros shared by the lsb stego extractor RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef LSB_STEGO_MESSAGE_EXTRACTOR_DEFINES_SVH
`define LSB_STEGO_MESSAGE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSBSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSBSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lsbse_pkg.sv -----
// Shared types and constants for the lsb stego message extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsbse_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 24;
  localparam int HLEN_W  = 4;
  localparam int HDR_W   = 64;
  localparam int WIN_MAX = 8;   // bytes the recent window can hold
  localparam int CFG_A_W = 2;

  localparam logic [BYTE_W-1:0]  TERMINATOR_BYTE = 8'hAA;
  localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 24'd65536;

  typedef enum logic [2:0] {
    EV_PAYLOAD       = 3'd0,
    EV_HEADER        = 3'd1,
    EV_TERMINATOR    = 3'd2,
    EV_OVERFLOW      = 3'd3,
    EV_END_NO_HEADER = 3'd4,
    EV_END_UNTERM    = 3'd5
  } event_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_HEADER_BYTES = 2'd0,
    REG_HDR_LEN      = 2'd1,
    REG_MAX_BYTES    = 2'd2
  } cfg_reg_t;

  // Control broadcast to every window cell.
  typedef struct packed {
    logic clr;    // drop held byte (start of image)
    logic shift;  // take neighbor's byte
  } cell_ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    event_t            ev;
  } result_t;

endpackage

// ----- hw/rtl/lsbse_cell.sv -----
// One byte cell of the recent-byte window, with its header byte compare.
// Depends on lsbse_pkg.
`timescale 1ns / 1ps

module lsbse_cell
  import lsbse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] prev_byte,  // from newer neighbor
  input  logic [BYTE_W-1:0] want,       // header byte expected here
  output logic [BYTE_W-1:0] cur_byte,   // to older neighbor
  output logic              eq
);

  logic [BYTE_W-1:0] held;
  logic [BYTE_W-1:0] held_next;

  assign cur_byte  = ctl.clr ? '0 : held;
  assign held_next = ctl.shift ? prev_byte : cur_byte;
  // compare against the window as it stands after a shift
  assign eq        = (prev_byte == want);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held_next;
    end
  end

endmodule

// ----- hw/rtl/lsbse_ofifo.sv -----
// Small result queue: up to two pushes and one pop per cycle.
// Depends on lsbse_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lsb_stego_message_extractor_defines.svh"

module lsbse_ofifo
  import lsbse_pkg::*;
#(
  parameter int DEPTH = 4  // power of two, at least 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  result_t    push_a,    // older of the two
  input  result_t    push_b,
  output logic       space2,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_word
);

  localparam int AW = $clog2(DEPTH);

  result_t       mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_word  = mem[rptr];
  assign space2    = (count <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr + AW'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(push_cnt);
      rptr  <= rptr + AW'(pop);
      count <= count + (AW+1)'(push_cnt) - (AW+1)'(pop);
    end
  end

  `LSBSE_ASSERT_SAME(a_count_bound, 1'b1, count <= (AW+1)'(DEPTH), "queue count past depth")
  `LSBSE_ASSERT_SAME(a_push_room, push_cnt != 2'd0, space2, "push without room for two")
  `LSBSE_ASSERT_SAME(a_push_legal, 1'b1, push_cnt != 2'd3, "more than two pushes")

endmodule

// ----- hw/rtl/lsb_stego_message_extractor.sv -----
// Top level of the lsb stego message extractor: bit gatherer, header window
// built from lsbse_cell, message control and the lsbse_ofifo result queue.
// Depends on lsbse_pkg, lsbse_cell, lsbse_ofifo and the assertion macro header.
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  pixel word: sample, first (tuser), last (tlast)
//  m_*       out  m_tvalid/m_tready  result word: data byte, event code (tuser)
//  cfg_*     in   cfg_we only        register write: index, 64-bit data
//
// One pixel word is taken per cycle while s_tready is high; its results are queued in the same cycle.
// A word makes at most two results; the queue (4 deep) takes a word only while
// room for two is left, so s_tready drops while three or more results wait.
// Results leave the queue oldest first, one per cycle while m_tready is high.
// Reset (rst, synchronous) clears extraction state, the queue and the registers
// to header length 0, header 0, capacity 65536.
`timescale 1ns / 1ps
`include "lsb_stego_message_extractor_defines.svh"

module lsb_stego_message_extractor
  import lsbse_pkg::*;
#(
  parameter int HEADER_MAX_BYTES = 8  // 1..16; window holds at most 8 bytes
) (
  input  logic                clk,
  input  logic                rst,
  // pixel stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] pixel_sample
  input  logic                s_tuser,   // [0] first_of_image
  input  logic                s_tlast,   // last_of_image
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] data_byte
  output logic [2:0]          m_tuser,   // [2:0] event_res
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [HDR_W-1:0]    cfg_wdata
);

  // cells actually used: the window never matches more than 8 bytes
  localparam int NCELLS = (HEADER_MAX_BYTES < WIN_MAX) ? HEADER_MAX_BYTES : WIN_MAX;

  // configuration registers
  logic [HDR_W-1:0]   header_bytes;
  logic [HLEN_W-1:0]  hdr_len;
  logic [COUNT_W-1:0] max_bytes;

  // extraction state
  logic [BYTE_W-1:0]  bit_shift;
  logic [2:0]         bit_count;
  logic [COUNT_W-1:0] byte_count;
  logic               header_seen;
  logic               finished;

  logic [BYTE_W-1:0]  bit_shift_next;
  logic [2:0]         bit_count_next;
  logic [COUNT_W-1:0] byte_count_next;
  logic               header_seen_next;
  logic               finished_next;

  logic               acc;
  logic [HLEN_W-1:0]  len_eff;
  logic [COUNT_W-1:0] limit;
  logic [BYTE_W-1:0]  bsh_new;
  logic               match;
  cell_ctl_t          cell_ctl;
  logic               shift_win;

  logic               r0_v;
  logic               r1_v;
  result_t            r0;
  result_t            r1;
  logic [1:0]         push_cnt;
  result_t            push_a;
  logic               space2;
  result_t            q_out;

  assign acc = s_tvalid && s_tready;
  assign s_tready = space2;

  // lengths above the window size act as the window size
  assign len_eff = (hdr_len > HLEN_W'(NCELLS)) ? HLEN_W'(NCELLS) : hdr_len;
  assign limit   = max_bytes - COUNT_W'(1);   // capacity 0 wraps to all ones

  // partial byte with this word's bit; a first-of-image word starts from zero
  assign bsh_new = {(s_tuser ? {(BYTE_W-1){1'b0}} : bit_shift[BYTE_W-2:0]), s_tdata[0]};

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= '0;
      hdr_len      <= '0;
      max_bytes    <= MAX_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEADER_BYTES: header_bytes <= cfg_wdata;
        REG_HDR_LEN:      hdr_len      <= cfg_wdata[HLEN_W-1:0];
        REG_MAX_BYTES:    max_bytes    <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Header window: a row of byte cells, newest byte in cell 0. Cell k holds the
  // byte k places back and checks it against header byte len-1-k.
  logic [BYTE_W-1:0] cell_byte [NCELLS];
  logic [NCELLS-1:0] hit;

  assign cell_ctl.clr   = acc && s_tuser;
  assign cell_ctl.shift = acc && shift_win;

  for (genvar k = 0; k < NCELLS; k++) begin : g_win
    logic [2:0]        hidx;
    logic [BYTE_W-1:0] want;
    logic [BYTE_W-1:0] prev;
    logic              eq;

    assign hidx = 3'(len_eff - HLEN_W'(k) - HLEN_W'(1));
    assign want = header_bytes[{hidx, 3'b000} +: BYTE_W];
    if (k == 0) begin : g_head
      assign prev = bsh_new;
    end else begin : g_body
      assign prev = cell_byte[k-1];
    end

    lsbse_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .prev_byte (prev),
      .want      (want),
      .cur_byte  (cell_byte[k]),
      .eq        (eq)
    );

    // cells past the header length don't take part
    assign hit[k] = (HLEN_W'(k) >= len_eff) || eq;
  end

  assign match = &hit;

  // ---------------------------------------------------------------------------
  // Message control. A first-of-image word sees cleared state.
  always_comb begin
    logic               fin_c;
    logic               hs_c;
    logic [COUNT_W-1:0] bc_c;
    logic [BYTE_W-1:0]  bsh_c;
    logic [2:0]         bcnt_c;
    logic [2:0]         bcnt_new;
    logic [COUNT_W-1:0] bc_inc;
    logic               active;

    fin_c  = s_tuser ? 1'b0 : finished;
    hs_c   = s_tuser ? 1'b0 : header_seen;
    bc_c   = s_tuser ? '0 : byte_count;
    bsh_c  = s_tuser ? '0 : bit_shift;
    bcnt_c = s_tuser ? '0 : bit_count;
    active = !fin_c;

    bcnt_new = bcnt_c + 3'd1;
    bc_inc   = bc_c + COUNT_W'(1);

    bit_shift_next   = bsh_c;
    bit_count_next   = bcnt_c;
    byte_count_next  = bc_c;
    header_seen_next = hs_c;
    finished_next    = fin_c;
    shift_win        = 1'b0;
    r0_v             = 1'b0;
    r0               = '{data: '0, ev: EV_PAYLOAD};
    r1_v             = 1'b0;
    r1               = '{data: '0, ev: EV_END_UNTERM};

    if (active) begin
      bit_shift_next = bsh_new;
      bit_count_next = bcnt_new;
      if (bcnt_new == 3'd0) begin
        bit_shift_next = '0;
        if (hs_c && bsh_new == TERMINATOR_BYTE) begin
          r0_v          = 1'b1;
          r0.ev         = EV_TERMINATOR;
          finished_next = 1'b1;
        end else if (bc_c < limit) begin
          byte_count_next = bc_inc;
          if (hs_c || len_eff == '0) begin
            r0_v    = 1'b1;
            r0.data = bsh_new;
            r0.ev   = EV_PAYLOAD;
          end else begin
            shift_win = 1'b1;
            if (bc_inc >= COUNT_W'(len_eff) && match) begin
              header_seen_next = 1'b1;
              byte_count_next  = '0;
              r0_v             = 1'b1;
              r0.ev            = EV_HEADER;
            end
          end
        end else begin
          r0_v          = 1'b1;
          r0.ev         = EV_OVERFLOW;
          finished_next = 1'b1;
        end
      end

      // end-of-image report follows this word's byte result, if any
      if (s_tlast && !finished_next) begin
        r1_v          = 1'b1;
        r1.ev         = (len_eff != '0 && !header_seen_next) ? EV_END_NO_HEADER
                                                             : EV_END_UNTERM;
        finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift   <= '0;
      bit_count   <= '0;
      byte_count  <= '0;
      header_seen <= 1'b0;
      finished    <= 1'b0;
    end else if (acc) begin
      bit_shift   <= bit_shift_next;
      bit_count   <= bit_count_next;
      byte_count  <= byte_count_next;
      header_seen <= header_seen_next;
      finished    <= finished_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue; results of one word go in oldest first.
  assign push_cnt = acc ? (2'(r0_v) + 2'(r1_v)) : 2'd0;
  assign push_a   = r0_v ? r0 : r1;

  lsbse_ofifo #(
    .DEPTH (4)
  ) u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (r1),
    .space2    (space2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (q_out)
  );

  assign m_tdata = q_out.data;
  assign m_tuser = q_out.ev;

  `LSBSE_ASSERT_NEXT(a_end_sets_finished, acc && r0_v && (r0.ev == EV_TERMINATOR || r0.ev == EV_OVERFLOW), finished, "message end did not stop extraction")
  `LSBSE_ASSERT_SAME(a_header_restarts_count, $rose(header_seen), byte_count == '0, "header found without count restart")
  `LSBSE_ASSERT_NEXT(a_first_clears_bits, acc && s_tuser, bit_count == 3'd1 && !header_seen, "first pixel did not clear state")

endmodule

// ----- tb/lsbse_tb_pkg.sv -----
// Scoreboard for the lsb stego message extractor bench: bit-exact predictor plus
// an in-order queue of expected result words. Depends on lsbse_pkg.
`timescale 1ns / 1ps

package lsbse_tb_pkg;
  import lsbse_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    event_t     ev;
  } extract_result_t;

  class extract_scoreboard;
    // configuration copy
    logic [63:0] hdr_bytes;
    logic [3:0]  hdr_len;
    logic [23:0] capacity;
    // extraction state
    logic [7:0]  shift_reg;
    logic [2:0]  bit_cnt;
    logic [23:0] byte_cnt;
    logic [63:0] window;
    bit          hdr_seen;
    bit          done;

    extract_result_t expected[$];
    int errors;
    int delivered;
    int tally[6];

    function new();
      hdr_bytes = '0;
      hdr_len   = '0;
      capacity  = MAX_BYTES_RESET;
      errors    = 0;
      delivered = 0;
      foreach (tally[i]) tally[i] = 0;
      clear();
    endfunction

    function void clear();
      shift_reg = '0;
      bit_cnt   = '0;
      byte_cnt  = '0;
      window    = '0;
      hdr_seen  = 0;
      done      = 0;
    endfunction

    function void set_config(logic [63:0] hb, logic [3:0] hl, logic [23:0] cap);
      hdr_bytes = hb;
      hdr_len   = hl;
      capacity  = cap;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // header byte 0 must line up with the oldest of the last len window bytes
    function bit header_hit(int unsigned len);
      logic [7:0] want, have;
      for (int unsigned i = 0; i < len; i++) begin
        want = 8'(hdr_bytes >> (8 * i));
        have = 8'(window >> (8 * (len - 1 - i)));
        if (want != have) return 0;
      end
      return 1;
    endfunction

    function void push(logic [7:0] data, event_t ev);
      extract_result_t r;
      r.data = data;
      r.ev   = ev;
      expected.push_back(r);
    endfunction

    // one accepted pixel word
    function void note_pixel(logic [7:0] sample, bit first, bit last);
      int unsigned len;
      logic [23:0] limit;
      logic [7:0]  b;
      len   = (hdr_len > 4'd8) ? 8 : hdr_len;
      limit = capacity - 24'd1;  // capacity 0 wraps to all ones
      if (first) clear();
      if (done) return;
      shift_reg = {shift_reg[6:0], sample[0]};
      bit_cnt   = bit_cnt + 3'd1;
      if (bit_cnt == 3'd0) begin
        b = shift_reg;
        shift_reg = '0;
        if (hdr_seen && b == TERMINATOR_BYTE) begin
          push(8'h00, EV_TERMINATOR);
          done = 1;
        end else if (byte_cnt < limit) begin
          byte_cnt = byte_cnt + 24'd1;
          if (hdr_seen || len == 0) begin
            push(b, EV_PAYLOAD);
          end else begin
            window = {window[55:0], b};
            if (byte_cnt >= len && header_hit(len)) begin
              hdr_seen = 1;
              byte_cnt = '0;
              push(8'h00, EV_HEADER);
            end
          end
        end else begin
          push(8'h00, EV_OVERFLOW);
          done = 1;
        end
      end
      // end-of-image report trails any result of the same pixel
      if (last && !done) begin
        push(8'h00, (len > 0 && !hdr_seen) ? EV_END_NO_HEADER : EV_END_UNTERM);
        done = 1;
      end
    endfunction

    // one accepted result word
    function void check_result(logic [7:0] data, logic [2:0] ev);
      extract_result_t r;
      delivered++;
      if (ev < 3'd6) tally[ev]++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: none expected, got data %02h event %0d", delivered, data, ev);
        return;
      end
      r = expected.pop_front();
      if (r.data !== data || r.ev !== ev) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected data %02h event %0d, got data %02h event %0d",
                   delivered, r.data, r.ev, data, ev);
      end
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
// Top-level bench for lsb_stego_message_extractor: directed and random images,
// random stalls on both streams. Depends on lsbse_pkg, lsbse_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import lsbse_pkg::*;
  import lsbse_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // [7:0] pixel_sample
  logic                s_tuser = 1'b0; // [0] first_of_image
  logic                s_tlast = 1'b0; // last_of_image
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;        // [7:0] data_byte
  logic [2:0]          m_tuser;        // [2:0] event_res
  logic                cfg_we = 1'b0;
  cfg_reg_t            cfg_addr = REG_HEADER_BYTES;
  logic [HDR_W-1:0]    cfg_wdata = '0;

  extract_scoreboard sb = new();

  int pixels = 0;
  int phases = 0;
  bit tx_calm = 0;  // sender never idles while set
  bit rx_calm = 0;  // sink never stalls while set
  int rx_hold = 0;

  always #5 clk = ~clk;

  lsb_stego_message_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Gap lengths: mostly none, some short, a few long.
  function automatic int pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sink side: check every accepted result word, then pick next tready.
  always @(posedge clk) begin : sink_side
    int g;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      g = pick_gap(rx_calm);
      if (g == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold  <= g - 1;
      end
    end
  end

  // Drive one pixel word and wait for the handshake. Called at a rising edge.
  // tvalid stays high between back-to-back words; this task drops it only for a gap.
  task automatic send_pixel(input logic [7:0] smp, input bit first, input bit last);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(smp, first, last);
    pixels++;
  endtask

  // Random upper bits; only bit 0 carries message data.
  function automatic logic [7:0] carrier(bit b);
    logic [7:0] smp;
    smp = 8'($urandom());
    smp[0] = b;
    return smp;
  endfunction

  // Let the block empty out: wait until no expected result is left, then let the
  // clock run on with tvalid low.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // All three registers, back to back; only called with the block drained.
  task automatic write_config(input logic [63:0] hb, input logic [3:0] hl,
                              input logic [23:0] cap);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_HEADER_BYTES;
    cfg_wdata <= hb;
    @(posedge clk);
    cfg_addr  <= REG_HDR_LEN;
    cfg_wdata <= {60'd0, hl};
    @(posedge clk);
    cfg_addr  <= REG_MAX_BYTES;
    cfg_wdata <= {40'd0, cap};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_config(hb, hl, cap);
    phases++;
  endtask

  function automatic void push_byte(ref bit q[$], input logic [7:0] b);
    for (int i = 7; i >= 0; i--) q.push_back(b[i]);
  endfunction

  // One image: mostly well formed (noise, header, payload, terminator, tail),
  // sometimes raw noise with random first/last flags.
  task automatic run_image(input logic [63:0] hb, input int unsigned len);
    bit q[$];
    logic [7:0] b;
    int n;
    bit with_last;
    tx_calm = ($urandom_range(0, 4) == 0);
    rx_calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        send_pixel(8'($urandom()), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      return;
    end
    n = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) push_byte(q, 8'($urandom()));
    if (len > 0 && $urandom_range(0, 4) != 0) begin
      for (int unsigned i = 0; i < len; i++) begin
        b = 8'(hb >> (8 * i));
        if ($urandom_range(0, 9) == 0) b = b ^ 8'(1 << $urandom_range(0, 7));
        push_byte(q, b);
      end
    end
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom());
      if ($urandom_range(0, 7) == 0) b = TERMINATOR_BYTE;
      push_byte(q, b);
    end
    if ($urandom_range(0, 4) != 0) push_byte(q, TERMINATOR_BYTE);
    n = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) q.push_back(1'($urandom()));
    if (q.size() == 0) q.push_back(1'($urandom()));
    with_last = ($urandom_range(0, 6) != 0);
    foreach (q[i])
      send_pixel(carrier(q[i]), i == 0, with_last && i == q.size() - 1);
  endtask

  initial begin : stimulus
    logic [63:0] hb;
    logic [3:0]  hl;
    logic [23:0] cap;
    int unsigned r;
    int imgs;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset config (no header): 0xAA is plain payload, end reports unterminated,
    // a finished image ignores pixels, first and last on one pixel.
    send_pixel(8'hFF, 1, 0);
    send_pixel(8'h00, 0, 0);
    send_pixel(8'hFF, 0, 0);
    send_pixel(8'h00, 0, 0);
    send_pixel(8'hFF, 0, 0);
    send_pixel(8'h00, 0, 0);
    send_pixel(8'hFF, 0, 0);
    send_pixel(8'h00, 0, 0);
    send_pixel(8'h81, 0, 1);
    send_pixel(8'h7E, 0, 0);
    send_pixel(8'h01, 1, 1);
    drain();

    // Long header length acts as 8; capacity 1 overflows on the first byte.
    write_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 24'd1);
    for (int i = 0; i < 8; i++) send_pixel(8'hFF, i == 0, 0);
    drain();

    // Capacity 0 wraps to the largest limit; short image ends with no header.
    write_config(64'd0, 4'd1, 24'd0);
    send_pixel(8'h00, 1, 0);
    send_pixel(8'hFE, 0, 1);
    drain();

    // Random phases: fresh config, a few images, then drain.
    while (pixels < 500) begin
      r = $urandom_range(0, 9);
      hb = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom(), $urandom()};
      r = $urandom_range(0, 9);
      hl = (r < 2) ? 4'd0 : (r < 7) ? 4'($urandom_range(1, 3)) :
           (r < 9) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(9, 15));
      r = $urandom_range(0, 9);
      cap = (r < 3) ? 24'($urandom_range(1, 8)) : (r == 3) ? 24'd0 :
            (r == 4) ? 24'hFFFFFF : (r < 7) ? MAX_BYTES_RESET :
            24'($urandom_range(100, 5000));
      write_config(hb, hl, cap);
      imgs = $urandom_range(1, 3);
      for (int i = 0; i < imgs; i++) run_image(hb, (hl > 4'd8) ? 8 : hl);
      drain();
    end

    rx_calm = 0;
    drain();
    repeat (10) @(posedge clk);

    $display("ran %0d pixel words over %0d configurations, %0d result words checked",
             pixels, phases, sb.delivered);
    $display("events: payload %0d header %0d terminator %0d overflow %0d no-header %0d open %0d",
             sb.tally[0], sb.tally[1], sb.tally[2], sb.tally[3], sb.tally[4], sb.tally[5]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lsb_stego_message_extractor: match");
    end else begin
      $display("lsb_stego_message_extractor: mismatch");
    end
    $finish;
  end

  // Hard limit, far above the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("lsb_stego_message_extractor: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lsbse_pkg.sv
hw/rtl/lsbse_cell.sv
hw/rtl/lsbse_ofifo.sv
hw/rtl/lsb_stego_message_extractor.sv
tb/lsbse_tb_pkg.sv
tb/tb.sv
